FILE: src/ott_pkg.sv
// Shared types and codes for the one-shot timer table.
// Holds slot record type, cell command struct, op/mode/status codes.
// No dependencies.
package ott_pkg;

  // Most firings reported by one tick sweep
  localparam int MAX_RESULTS = 16;
  localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);

  // Operation codes
  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DESTROY = 2'd1;
  localparam logic [1:0] OP_FIND    = 2'd2;
  localparam logic [1:0] OP_TICK    = 2'd3;

  // Slot modes
  localparam logic [1:0] MODE_DEAD  = 2'd0;
  localparam logic [1:0] MODE_SECS  = 2'd1;
  localparam logic [1:0] MODE_TICKS = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_BAD_ID    = 2'd1;
  localparam logic [1:0] STAT_BAD_MODE  = 2'd2;
  localparam logic [1:0] STAT_BAD_OWNER = 2'd3;

  // One timer slot
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] count;
    logic [31:0] owner;
  } slot_t;

  // Addressed command broadcast to the cells
  typedef struct packed {
    logic arm;
    logic kill;
  } slot_cmd_t;

endpackage

FILE: src/ott_intf.sv
// Request and result channel interfaces of the one-shot timer table.
// Valid/ready handshake; no dependencies.
interface ott_in_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  slot_id;
  logic [31:0] delay_amount;
  logic [1:0]  unit_mode;
  logic [31:0] owner_tag;
  logic        owner_ok;
  logic [31:0] now_seconds;

  modport source (output valid, op, slot_id, delay_amount, unit_mode, owner_tag,
                  owner_ok, now_seconds, input ready);
  modport sink (input valid, op, slot_id, delay_amount, unit_mode, owner_tag,
                owner_ok, now_seconds, output ready);
endinterface

interface ott_out_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  free_slot;
  logic        fired;
  logic [31:0] fired_tag;
  logic        last;

  modport source (output valid, status, free_slot, fired, fired_tag, last,
                  input ready);
  modport sink (input valid, status, free_slot, fired, fired_tag, last,
                output ready);
endinterface

FILE: src/ott_cell.sv
// One timer slot cell of the shift ring.
// Depends on ott_pkg (slot_t, slot_cmd_t, mode codes).
module ott_cell import ott_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] slot_id,
  input  slot_cmd_t  cmd,
  input  slot_t      wr,
  input  logic       shift_en,
  input  slot_t      shift_in,
  output logic       sel,
  output slot_t      q
);

  logic [1:0]  mode_r, mode_nxt;
  logic [31:0] count_r, count_nxt;
  logic [31:0] owner_r, owner_nxt;

  // Address decode against this cell's home slot
  assign sel = (slot_id == 8'(INDEX));

  // Rotation has priority; addressed writes only happen while idle
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    owner_nxt = owner_r;
    priority if (shift_en) begin
      mode_nxt  = shift_in.mode;
      count_nxt = shift_in.count;
      owner_nxt = shift_in.owner;
    end else if (sel && cmd.kill) begin
      mode_nxt = MODE_DEAD;
    end else if (sel && cmd.arm) begin
      mode_nxt  = wr.mode;
      count_nxt = wr.count;
      owner_nxt = wr.owner;
    end else begin
      // not addressed: hold
      mode_nxt = mode_r;
    end
  end

  // Mode is control state and resets to dead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_DEAD;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
    owner_r <= owner_nxt;
  end

  assign q.mode  = mode_r;
  assign q.count = count_r;
  assign q.owner = owner_r;

endmodule

FILE: src/one_shot_timer_table_core.sv
// One-shot timer table: ring of TIMER_SLOTS slot cells plus sweep controller.
// Create/destroy: result registered in the cycle after the request; 1 request per
// cycle while results are taken. Tick/find-free: the ring rotates one slot per cycle
// past the head processor while no firing waits on the output; final result on flush.
// Reset (synchronous, rst_n low): all slots dead, controller idle, no result pending.
// Depends on ott_pkg, ott_intf (ott_in_if, ott_out_if) and ott_cell.
module one_shot_timer_table_core import ott_pkg::*; #(
  parameter int TIMER_SLOTS = 16
) (
  input logic   clk,
  input logic   rst_n,
  ott_in_if.sink    in_req,
  ott_out_if.source out_rsp
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [FIRE_W-1:0] fires_r, fires_nxt;
  logic              pend_valid_r, pend_valid_nxt;
  logic [31:0]       pend_tag_r, pend_tag_nxt;
  logic              found_v_r, found_v_nxt;
  logic [IDX_W-1:0]  found_r, found_nxt;
  logic [31:0]       now_r, now_nxt;
  logic              is_tick_r, is_tick_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  logic [3:0]  out_free_slot_r, out_free_slot_nxt;
  logic        out_fired_r, out_fired_nxt;
  logic [31:0] out_tag_r, out_tag_nxt;
  logic        out_last_r, out_last_nxt;

  slot_t            cell_q [TIMER_SLOTS];
  logic [TIMER_SLOTS-1:0] sel_vec, live_vec;
  slot_cmd_t        cmd;
  slot_t            wr;
  slot_t            head, head_nxt;
  logic             hit, sel_live;
  logic [1:0]       create_st;
  logic [31:0]      dec;
  logic             fire, push, advance, out_free, in_accept, sweep_end;

  // Slot ring: cell 0 is the head, processed head re-enters at the tail
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    slot_t shift_in;
    if (i == TIMER_SLOTS - 1) begin : g_tail
      assign shift_in = head_nxt;
    end else begin : g_mid
      assign shift_in = cell_q[i+1];
    end
    ott_cell #(.INDEX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_id  (in_req.slot_id),
      .cmd      (cmd),
      .wr       (wr),
      .shift_en (advance),
      .shift_in (shift_in),
      .sel      (sel_vec[i]),
      .q        (cell_q[i])
    );
    assign live_vec[i] = (cell_q[i].mode != MODE_DEAD);
  end

  // Addressed checks for create/destroy
  assign hit      = |sel_vec;
  assign sel_live = |(sel_vec & live_vec);

  always_comb begin
    priority if (!hit || sel_live) begin
      create_st = STAT_BAD_ID;
    end else if (in_req.unit_mode != MODE_SECS && in_req.unit_mode != MODE_TICKS) begin
      create_st = STAT_BAD_MODE;
    end else if (!in_req.owner_ok) begin
      create_st = STAT_BAD_OWNER;
    end else begin
      create_st = STAT_OK;
    end
  end

  // Write data for an armed slot
  assign wr.mode  = in_req.unit_mode;
  assign wr.count = (in_req.unit_mode == MODE_TICKS) ? in_req.delay_amount
                                                     : in_req.now_seconds + in_req.delay_amount;
  assign wr.owner = in_req.owner_tag;

  // Head processor: countdown or deadline check, capped per sweep
  assign head = cell_q[0];
  assign dec  = head.count - 32'd1;

  always_comb begin
    head_nxt = head;
    fire     = 1'b0;
    if (is_tick_r && fires_r != FIRE_W'(MAX_RESULTS)) begin
      priority if (head.mode == MODE_TICKS) begin
        head_nxt.count = dec;
        fire           = (dec == 32'd0);
      end else if (head.mode == MODE_SECS) begin
        fire = (head.count <= now_r);
      end else begin
        // dead slot: nothing to do
        fire = 1'b0;
      end
      if (fire) begin
        head_nxt.mode = MODE_DEAD;
      end
    end
  end

  // Handshake and sweep stepping
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign in_accept = in_req.valid && in_req.ready;
  assign push      = fire && pend_valid_r;
  assign advance   = (state_r == ST_SWEEP) && (!push || out_free);
  assign sweep_end = (idx_r == IDX_W'(TIMER_SLOTS - 1));

  // Controller next state
  always_comb begin
    state_nxt         = state_r;
    idx_nxt           = idx_r;
    fires_nxt         = fires_r;
    pend_valid_nxt    = pend_valid_r;
    pend_tag_nxt      = pend_tag_r;
    found_v_nxt       = found_v_r;
    found_nxt         = found_r;
    now_nxt           = now_r;
    is_tick_nxt       = is_tick_r;
    out_valid_nxt     = out_valid_r && !out_rsp.ready;
    out_status_nxt    = out_status_r;
    out_free_slot_nxt = out_free_slot_r;
    out_fired_nxt     = out_fired_r;
    out_tag_nxt       = out_tag_r;
    out_last_nxt      = out_last_r;
    cmd               = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_req.op)
            OP_CREATE: begin
              cmd.arm           = (create_st == STAT_OK);
              out_valid_nxt     = 1'b1;
              out_status_nxt    = create_st;
              out_free_slot_nxt = 4'd0;
              out_fired_nxt     = 1'b0;
              out_tag_nxt       = 32'd0;
              out_last_nxt      = 1'b1;
            end
            OP_DESTROY: begin
              cmd.kill          = hit;
              out_valid_nxt     = 1'b1;
              out_status_nxt    = hit ? STAT_OK : STAT_BAD_ID;
              out_free_slot_nxt = 4'd0;
              out_fired_nxt     = 1'b0;
              out_tag_nxt       = 32'd0;
              out_last_nxt      = 1'b1;
            end
            OP_FIND, OP_TICK: begin
              state_nxt      = ST_SWEEP;
              idx_nxt        = '0;
              fires_nxt      = '0;
              pend_valid_nxt = 1'b0;
              found_v_nxt    = 1'b0;
              now_nxt        = in_req.now_seconds;
              is_tick_nxt    = (in_req.op == OP_TICK);
            end
          endcase
        end
      end
      ST_SWEEP: begin
        if (advance) begin
          idx_nxt = idx_r + IDX_W'(1);
          // previous firing is not the last one: send it on
          if (push) begin
            out_valid_nxt     = 1'b1;
            out_status_nxt    = STAT_OK;
            out_free_slot_nxt = 4'd0;
            out_fired_nxt     = 1'b1;
            out_tag_nxt       = pend_tag_r;
            out_last_nxt      = 1'b0;
          end
          if (fire) begin
            fires_nxt      = fires_r + FIRE_W'(1);
            pend_valid_nxt = 1'b1;
            pend_tag_nxt   = head.owner;
          end
          if (!is_tick_r && !found_v_r && head.mode == MODE_DEAD) begin
            found_v_nxt = 1'b1;
            found_nxt   = idx_r;
          end
          if (sweep_end) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (is_tick_r) begin
            out_status_nxt    = STAT_OK;
            out_free_slot_nxt = 4'd0;
            out_fired_nxt     = pend_valid_r;
            out_tag_nxt       = pend_valid_r ? pend_tag_r : 32'd0;
          end else begin
            out_status_nxt    = found_v_r ? STAT_OK : STAT_BAD_ID;
            out_free_slot_nxt = found_v_r ? 4'(found_r) : 4'd0;
            out_fired_nxt     = 1'b0;
            out_tag_nxt       = 32'd0;
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      fires_r      <= '0;
      pend_valid_r <= 1'b0;
      found_v_r    <= 1'b0;
      is_tick_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      fires_r      <= fires_nxt;
      pend_valid_r <= pend_valid_nxt;
      found_v_r    <= found_v_nxt;
      is_tick_r    <= is_tick_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_tag_r      <= pend_tag_nxt;
    found_r         <= found_nxt;
    now_r           <= now_nxt;
    out_status_r    <= out_status_nxt;
    out_free_slot_r <= out_free_slot_nxt;
    out_fired_r     <= out_fired_nxt;
    out_tag_r       <= out_tag_nxt;
    out_last_r      <= out_last_nxt;
  end

  // Ports
  assign in_req.ready      = (state_r == ST_IDLE) && out_free;
  assign out_rsp.valid     = out_valid_r;
  assign out_rsp.status    = out_status_r;
  assign out_rsp.free_slot = out_free_slot_r;
  assign out_rsp.fired     = out_fired_r;
  assign out_rsp.fired_tag = out_tag_r;
  assign out_rsp.last      = out_last_r;

  // Firing count never passes the per-sweep cap
  a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fires_r <= FIRE_W'(MAX_RESULTS))
    else $error("firing count above cap");

  // A held firing never survives into idle
  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> state_r != ST_IDLE)
    else $error("pending firing left in idle");

  // Results shown mid-sweep are firings that are not the last
  a_sweep_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) && out_valid_r |-> out_rsp.fired && !out_rsp.last)
    else $error("bad result during sweep");

  // Flush hands off the final result and returns to idle
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) && out_free |=> (state_r == ST_IDLE) && out_valid_r && out_rsp.last)
    else $error("flush did not complete");

  // Create and destroy answer with one final result in the next cycle
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && (in_req.op == OP_CREATE || in_req.op == OP_DESTROY)
      |=> out_valid_r && out_rsp.last && (state_r == ST_IDLE))
    else $error("missing create/destroy result");

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for one_shot_timer_table_core: drives create, destroy,
// find-free and tick requests and checks every result against a built-in predictor.
// Depends on ott_pkg, ott_intf (ott_in_if, ott_out_if) and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ott_pkg::*;

  localparam int SLOTS        = 16;
  localparam int RANDOM_REQS  = 70;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTED = 10;
  // unit_mode value that is never valid besides MODE_DEAD
  localparam logic [1:0] MODE_BAD = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  slot_id;
    logic [31:0] delay_amount;
    logic [1:0]  unit_mode;
    logic [31:0] owner_tag;
    logic        owner_ok;
    logic [31:0] now_seconds;
  } timer_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  free_slot;
    logic        fired;
    logic [31:0] fired_tag;
    logic        last;
  } timer_rsp_t;

  logic clk;
  logic rst_n;

  ott_in_if  req_if ();
  ott_out_if rsp_if ();

  one_shot_timer_table_core #(.TIMER_SLOTS(SLOTS)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_if),
    .out_rsp(rsp_if)
  );

  // Predicted slot table
  logic [1:0]  tmr_mode  [SLOTS];
  logic [31:0] tmr_count [SLOTS];
  logic [31:0] tmr_owner [SLOTS];
  timer_rsp_t  pending_results[$];

  int          err_count;
  int          req_count;
  int          rsp_count;
  int          expiry_count;
  int          cycle_count;
  int          burst_left;
  bit          calm_sender;
  logic [31:0] clock_secs;
  int          stall_mode;
  int          stall_left;

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic timer_rsp_t mk_rsp(logic [1:0] st, logic [3:0] fs, logic fd,
                                        logic [31:0] tag, logic lst);
    timer_rsp_t r;
    r.status    = st;
    r.free_slot = fs;
    r.fired     = fd;
    r.fired_tag = tag;
    r.last      = lst;
    return r;
  endfunction

  function automatic void predict_timer_results(timer_req_t r);
    logic [1:0] st;
    int         n;
    bit         fire;
    bit         found;
    timer_rsp_t sweep[$];
    case (r.op)
      OP_CREATE: begin
        if (int'(r.slot_id) >= SLOTS || tmr_mode[r.slot_id] != MODE_DEAD) begin
          st = STAT_BAD_ID;
        end else if (r.unit_mode != MODE_SECS && r.unit_mode != MODE_TICKS) begin
          st = STAT_BAD_MODE;
        end else if (!r.owner_ok) begin
          st = STAT_BAD_OWNER;
        end else begin
          st = STAT_OK;
          tmr_mode[r.slot_id]  = r.unit_mode;
          tmr_owner[r.slot_id] = r.owner_tag;
          tmr_count[r.slot_id] = (r.unit_mode == MODE_TICKS) ? r.delay_amount
                                 : r.now_seconds + r.delay_amount;
        end
        pending_results.push_back(mk_rsp(st, 4'd0, 1'b0, 32'd0, 1'b1));
      end
      OP_DESTROY: begin
        if (int'(r.slot_id) >= SLOTS) begin
          pending_results.push_back(mk_rsp(STAT_BAD_ID, 4'd0, 1'b0, 32'd0, 1'b1));
        end else begin
          tmr_mode[r.slot_id] = MODE_DEAD;
          pending_results.push_back(mk_rsp(STAT_OK, 4'd0, 1'b0, 32'd0, 1'b1));
        end
      end
      OP_FIND: begin
        found = 1'b0;
        for (int i = 0; i < SLOTS && !found; i++) begin
          if (tmr_mode[i] == MODE_DEAD) begin
            found = 1'b1;
            pending_results.push_back(mk_rsp(STAT_OK, 4'(i), 1'b0, 32'd0, 1'b1));
          end
        end
        if (!found) pending_results.push_back(mk_rsp(STAT_BAD_ID, 4'd0, 1'b0, 32'd0, 1'b1));
      end
      default: begin
        // tick: sweep in slot order, stop once the firing cap is hit
        n = 0;
        for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
          fire = 1'b0;
          if (tmr_mode[i] == MODE_TICKS) begin
            tmr_count[i] = tmr_count[i] - 32'd1;
            fire = (tmr_count[i] == 32'd0);
          end else if (tmr_mode[i] == MODE_SECS) begin
            fire = (tmr_count[i] <= r.now_seconds);
          end
          if (fire) begin
            tmr_mode[i] = MODE_DEAD;
            sweep.push_back(mk_rsp(STAT_OK, 4'd0, 1'b1, tmr_owner[i], 1'b0));
            n++;
          end
        end
        if (n == 0) begin
          pending_results.push_back(mk_rsp(STAT_OK, 4'd0, 1'b0, 32'd0, 1'b1));
        end else begin
          sweep[n-1].last = 1'b1;
          foreach (sweep[k]) pending_results.push_back(sweep[k]);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic string show_rsp(timer_rsp_t r);
    return $sformatf("status=%0d free_slot=%0d fired=%0d tag=%08h last=%0d",
                     r.status, r.free_slot, r.fired, r.fired_tag, r.last);
  endfunction

  function automatic void note_failure(string msg);
    err_count++;
    if (err_count <= MAX_REPORTED) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : check_results
    timer_rsp_t got;
    timer_rsp_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got = mk_rsp(rsp_if.status, rsp_if.free_slot, rsp_if.fired, rsp_if.fired_tag,
                   rsp_if.last);
      rsp_count++;
      if (got.fired) expiry_count++;
      if (pending_results.size() == 0) begin
        note_failure({"result with nothing expected: ", show_rsp(got)});
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.free_slot !== want.free_slot ||
            got.fired !== want.fired || got.fired_tag !== want.fired_tag ||
            got.last !== want.last) begin
          note_failure({"expected ", show_rsp(want), " got ", show_rsp(got)});
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result-side backpressure: one of four stall patterns, picked anew at random from time to time
  always @(negedge clk) begin
    if (cycle_count % 97 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rsp_if.ready <= 1'b1;
      1: rsp_if.ready <= 1'($urandom_range(0, 1));
      2: rsp_if.ready <= (cycle_count % 5) < 3;
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  function automatic timer_req_t mk_req(logic [1:0] op, logic [7:0] id, logic [31:0] dly,
                                        logic [1:0] mode, logic [31:0] tag, logic ok,
                                        logic [31:0] now);
    timer_req_t r;
    r.op           = op;
    r.slot_id      = id;
    r.delay_amount = dly;
    r.unit_mode    = mode;
    r.owner_tag    = tag;
    r.owner_ok     = ok;
    r.now_seconds  = now;
    return r;
  endfunction

  // Send one request, predict on acceptance, then maybe idle between bursts
  task automatic send_req(input timer_req_t r);
    int gap;
    @(negedge clk);
    req_if.valid        <= 1'b1;
    req_if.op           <= r.op;
    req_if.slot_id      <= r.slot_id;
    req_if.delay_amount <= r.delay_amount;
    req_if.unit_mode    <= r.unit_mode;
    req_if.owner_tag    <= r.owner_tag;
    req_if.owner_ok     <= r.owner_ok;
    req_if.now_seconds  <= r.now_seconds;
    do @(posedge clk); while (!req_if.ready);
    predict_timer_results(r);
    req_count++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 8);
      gap = calm_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic timer_req_t random_req();
    timer_req_t r;
    int         pick;
    int         dead_ids[$];
    r = mk_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), $urandom(),
               2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)), $urandom());
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      r.op = OP_CREATE;
      for (int i = 0; i < SLOTS; i++) if (tmr_mode[i] == MODE_DEAD) dead_ids.push_back(i);
      if (dead_ids.size() > 0 && $urandom_range(0, 3) != 0)
        r.slot_id = 8'(dead_ids[$urandom_range(0, dead_ids.size() - 1)]);
      else if ($urandom_range(0, 1) == 0)
        r.slot_id = 8'($urandom_range(0, SLOTS - 1));
      if ($urandom_range(0, 9) != 0) r.unit_mode = $urandom_range(0, 1) ? MODE_SECS : MODE_TICKS;
      r.owner_ok = ($urandom_range(0, 11) != 0);
      case ($urandom_range(0, 9))
        7, 8:    r.delay_amount = $urandom();
        9:       r.delay_amount = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
        default: r.delay_amount = $urandom_range(0, 6);
      endcase
      r.now_seconds = clock_secs;
    end else if (pick < 75) begin
      r.op = OP_TICK;
      if ($urandom_range(0, 24) == 0) clock_secs = $urandom();
      else clock_secs = clock_secs + $urandom_range(0, 3);
      r.now_seconds = clock_secs;
    end else if (pick < 90) begin
      r.op = OP_DESTROY;
      if ($urandom_range(0, 4) != 0) r.slot_id = 8'($urandom_range(0, SLOTS - 1));
    end else begin
      r.op = OP_FIND;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty table: find-free, quiet tick, destroy of a dead slot
  task automatic test_reset_state();
    send_req(mk_req(OP_FIND, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
    send_req(mk_req(OP_TICK, 8'd7, 32'd5, MODE_SECS, 32'h1234, 1'b1, 32'd0));
    send_req(mk_req(OP_DESTROY, 8'd3, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
  endtask

  // Create check order: id/busy, then mode, then owner
  task automatic test_create_checks();
    send_req(mk_req(OP_CREATE, 8'd255, 32'd1, MODE_DEAD, 32'h1, 1'b0, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd16, 32'd1, MODE_SECS, 32'h2, 1'b1, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd0, 32'd1, MODE_DEAD, 32'h3, 1'b0, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd0, 32'd1, MODE_BAD, 32'h4, 1'b1, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd0, 32'd1, MODE_TICKS, 32'h5, 1'b0, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd0, 32'd1, MODE_TICKS, 32'hFFFF_FFFF, 1'b1, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd0, 32'd9, MODE_SECS, 32'h6, 1'b1, 32'd0));
    send_req(mk_req(OP_FIND, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
  endtask

  // Tick countdown: zero count wraps without firing, destroy live and bad ids
  task automatic test_countdown();
    send_req(mk_req(OP_CREATE, 8'd1, 32'd0, MODE_TICKS, 32'hA5A5_0001, 1'b1, 32'd0));
    send_req(mk_req(OP_CREATE, 8'd2, 32'd2, MODE_TICKS, 32'h5A5A_0002, 1'b1, 32'd0));
    send_req(mk_req(OP_TICK, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
    send_req(mk_req(OP_TICK, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
    send_req(mk_req(OP_DESTROY, 8'd1, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
    send_req(mk_req(OP_DESTROY, 8'd200, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
  endtask

  // Seconds deadlines: sum wrapping past 2^32, equal deadline fires
  task automatic test_deadline();
    send_req(mk_req(OP_CREATE, 8'd3, 32'h20, MODE_SECS, 32'hD00D_0003, 1'b1, 32'hFFFF_FFF0));
    send_req(mk_req(OP_CREATE, 8'd4, 32'hFFFF_FFFF, MODE_SECS, 32'hD00D_0004, 1'b1, 32'd100));
    send_req(mk_req(OP_CREATE, 8'd5, 32'd10, MODE_SECS, 32'hD00D_0005, 1'b1, 32'd50));
    send_req(mk_req(OP_TICK, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd60));
    send_req(mk_req(OP_TICK, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd99));
  endtask

  // Fill every dead slot, find-free with none free, then one tick fires all
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++) begin
      if (tmr_mode[i] == MODE_DEAD)
        send_req(mk_req(OP_CREATE, 8'(i), 32'd1, MODE_TICKS, $urandom(), 1'b1, $urandom()));
    end
    send_req(mk_req(OP_FIND, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
    send_req(mk_req(OP_TICK, 8'd0, 32'd0, MODE_DEAD, 32'd0, 1'b0, 32'd0));
  endtask

  // Mostly well-formed create/tick traffic, plus destroy and find-free, with noise mixed in
  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n % 20 == 0) calm_sender = ($urandom_range(0, 2) == 0);
      send_req(random_req());
    end
    calm_sender = 1'b0;
  endtask

  initial begin
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.op           = OP_CREATE;
    req_if.slot_id      = 8'd0;
    req_if.delay_amount = 32'd0;
    req_if.unit_mode    = MODE_DEAD;
    req_if.owner_tag    = 32'd0;
    req_if.owner_ok     = 1'b0;
    req_if.now_seconds  = 32'd0;
    rsp_if.ready        = 1'b0;
    err_count    = 0;
    req_count    = 0;
    rsp_count    = 0;
    expiry_count = 0;
    cycle_count  = 0;
    burst_left   = 1;
    calm_sender  = 1'b0;
    stall_mode   = 0;
    stall_left   = 0;
    clock_secs   = $urandom();
    for (int i = 0; i < SLOTS; i++) begin
      tmr_mode[i]  = MODE_DEAD;
      tmr_count[i] = 32'd0;
      tmr_owner[i] = 32'd0;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_create_checks();
    test_countdown();
    test_deadline();
    test_full_table();
    test_random_traffic();

    // Drain: everything expected, then a quiet window for stray results
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4 * SLOTS) @(posedge clk);

    $display("Run: %0d requests, %0d results checked, %0d timer expiries, %0d mismatches",
             req_count, rsp_count, expiry_count, err_count);
    $display("Covered create check order, destroy, find-free on empty and full table, %s",
             "countdown wrap and seconds deadlines across the 32-bit wrap");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
